// ===== rtl/kpdf_pkg.sv =====
// Package with the shared types, codes and sizes of the keyed slot pool.
`timescale 1ns / 1ps
package kpdf_pkg;

    // Pool size and the widths that follow from it.
    localparam int POOL_SLOTS = 16;
    localparam int IDX_W      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CNT_W      = $clog2(POOL_SLOTS + 1);

    // Fixed field widths of the request and result.
    localparam int KIND_W  = 2;
    localparam int KEY_W   = 8;
    localparam int SLOT_W  = 4;
    localparam int STAT_W  = 3;
    localparam int LIM_W   = 5;
    localparam int PHASE_W = 2;

    // Width that holds both a slot count and the key limit.
    localparam int OC_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;
    // Width that holds both a slot handle and a slot count.
    localparam int SC_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(4);
    localparam logic [KEY_W-1:0] KEY_NULL    = '0;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD     = 2'd0,
        KIND_RESERVE = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_TICK    = 2'd3
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STS_OK      = 3'd0,
        STS_NULL    = 3'd1,
        STS_FULL    = 3'd2,
        STS_LIMIT   = 3'd3,
        STS_NONE    = 3'd4,
        STS_MISSING = 3'd5
    } status_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_FREE    = 2'd0,
        PH_BUSY    = 2'd1,
        PH_PENDING = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_START,
        CS_SCAN,
        CS_DONE
    } ctrl_state_t;

    typedef struct packed {
        kind_t              kind;
        logic [KEY_W-1:0]   key;
        logic [SLOT_W-1:0]  slot;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  granted_slot;
    } out_item_t;

    // Memory accesses issued by the sequencer in one cycle.
    typedef struct packed {
        logic [IDX_W-1:0]  rd_addr;
        logic              tag_we;
        logic              phase_we;
        logic [IDX_W-1:0]  wr_addr;
        logic [KEY_W-1:0]  tag_wdata;
        phase_t            phase_wdata;
    } mem_req_t;

endpackage

// ===== rtl/kpdf_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module kpdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data.
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/kpdf_ctrl.sv =====
// Request sequencer: decodes a request, scans the slot memories and writes back.
`timescale 1ns / 1ps
module kpdf_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  kpdf_pkg::in_item_t         s_data,
    input  logic                       cfg_valid,
    input  logic [kpdf_pkg::LIM_W-1:0] cfg_data,
    output kpdf_pkg::mem_req_t         mem_req,
    input  logic [kpdf_pkg::KEY_W-1:0] tag_q,
    input  kpdf_pkg::phase_t           phase_q,
    output logic                       res_valid,
    input  logic                       res_ready,
    output kpdf_pkg::out_item_t        res_data
);
    import kpdf_pkg::*;

    ctrl_state_t         state_reg, state_next;
    in_item_t            req_reg, req_next;
    out_item_t           res_reg, res_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [LIM_W-1:0]    limit_reg;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    owned_reg, owned_next;
    logic                rd_v_reg, rd_v_next;
    logic [IDX_W-1:0]    pidx_reg, pidx_next;
    logic                issue;
    logic                tag_hit;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            used_reg  <= '0;
            limit_reg <= LIMIT_RESET;
            rd_v_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            rd_v_reg  <= rd_v_next;
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
        end
    end

    // Request, result and scan registers.
    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        res_reg   <= res_next;
        idx_reg   <= idx_next;
        owned_reg <= owned_next;
        pidx_reg  <= pidx_next;
    end

    assign s_ready   = (state_reg == CS_IDLE);
    assign res_valid = (state_reg == CS_DONE);
    assign res_data  = res_reg;
    assign issue     = (idx_reg < used_reg);
    assign tag_hit   = (tag_q == req_reg.key);

    // Next state, scan pipeline and memory accesses.
    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        used_next  = used_reg;
        idx_next   = idx_reg;
        owned_next = owned_reg;
        rd_v_next  = 1'b0;
        pidx_next  = pidx_reg;
        mem_req    = '0;
        mem_req.rd_addr = idx_reg[IDX_W-1:0];

        case (state_reg)
            CS_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    res_next   = '{status: STS_OK, granted_slot: '0};
                    state_next = CS_START;
                end
            end

            CS_START: begin
                idx_next   = '0;
                owned_next = '0;
                state_next = CS_SCAN;
                case (req_reg.kind)
                    KIND_ADD: begin
                        if (req_reg.key == KEY_NULL) begin
                            res_next.status = STS_NULL;
                            state_next      = CS_DONE;
                        end else if (OC_W'(used_reg) >= OC_W'(POOL_SLOTS)) begin
                            res_next.status = STS_FULL;
                            state_next      = CS_DONE;
                        end
                    end
                    KIND_RESERVE: begin
                        if (req_reg.key == KEY_NULL) begin
                            res_next.status = STS_NULL;
                            state_next      = CS_DONE;
                        end
                    end
                    KIND_RELEASE: begin
                        state_next = CS_DONE;
                        if (SC_W'(req_reg.slot) >= SC_W'(used_reg)) begin
                            res_next.status = STS_MISSING;
                        end else begin
                            mem_req.phase_we    = 1'b1;
                            mem_req.wr_addr     = IDX_W'(SC_W'(req_reg.slot));
                            mem_req.phase_wdata = PH_PENDING;
                        end
                    end
                    default: begin
                        // Tick walks every appended slot.
                    end
                endcase
            end

            CS_SCAN: begin
                // Issue the read of the next slot.
                if (issue) begin
                    idx_next  = idx_reg + CNT_W'(1);
                    rd_v_next = 1'b1;
                    pidx_next = idx_reg[IDX_W-1:0];
                end

                if (rd_v_reg) begin
                    // Examine the slot read in the previous cycle.
                    case (req_reg.kind)
                        KIND_ADD: begin
                            if (tag_hit) begin
                                owned_next = owned_reg + CNT_W'(1);
                            end
                        end
                        KIND_RESERVE: begin
                            if (tag_hit && phase_q == PH_FREE) begin
                                mem_req.phase_we     = 1'b1;
                                mem_req.wr_addr      = pidx_reg;
                                mem_req.phase_wdata  = PH_BUSY;
                                res_next.granted_slot = SLOT_W'(pidx_reg);
                                rd_v_next            = 1'b0;
                                state_next           = CS_DONE;
                            end
                        end
                        KIND_TICK: begin
                            if (phase_q == PH_PENDING) begin
                                mem_req.phase_we    = 1'b1;
                                mem_req.wr_addr     = pidx_reg;
                                mem_req.phase_wdata = PH_FREE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (!issue) begin
                    // Scan finished without an early hit.
                    state_next = CS_DONE;
                    case (req_reg.kind)
                        KIND_ADD: begin
                            if (OC_W'(owned_reg) >= OC_W'(limit_reg)) begin
                                res_next.status = STS_LIMIT;
                            end else begin
                                mem_req.tag_we        = 1'b1;
                                mem_req.phase_we      = 1'b1;
                                mem_req.wr_addr       = used_reg[IDX_W-1:0];
                                mem_req.tag_wdata     = req_reg.key;
                                mem_req.phase_wdata   = PH_FREE;
                                used_next             = used_reg + CNT_W'(1);
                                res_next.granted_slot = SLOT_W'(used_reg);
                            end
                        end
                        KIND_RESERVE: begin
                            res_next.status = STS_NONE;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            CS_DONE: begin
                if (res_ready) begin
                    state_next = CS_IDLE;
                end
            end

            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/keyed_pool_deferred_free.sv =====
// Top level of the keyed slot pool with deferred free.
//
// The block keeps up to 16 slots, each tagged with an 8-bit key and a phase.
// Requests enter on the s_ channel (valid/ready, one packed struct): add
// appends a free slot for a key, reserve takes the lowest free slot of a key,
// release marks a slot pending free and tick returns all pending slots to
// free. Every request produces exactly one result on the m_ channel with a
// status code and the granted slot.
// The per-key slot limit is written over the cfg_ channel, which is always
// ready; write it only while no request is in flight.
// Release, and an add or reserve refused at decode, go from decode straight
// to the result; add, reserve and tick walk the tag and phase memories one
// slot per cycle over the N slots appended so far (reserve stops at the
// first hit). One request is handled at a time: the next request is accepted
// only once the previous one has reached its result.
// The result sits in an output register, so a new request can be accepted
// while the previous result waits for m_ready; a stalled receiver only holds
// up the block once a second result is ready.
// Reset clears the slot count, restores the limit to 4 and empties the
// output register; the slot memories need no clearing.
`timescale 1ns / 1ps
module keyed_pool_deferred_free (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  kpdf_pkg::in_item_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output kpdf_pkg::out_item_t        m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [kpdf_pkg::LIM_W-1:0] cfg_data
);
    import kpdf_pkg::*;

    mem_req_t          mem_req;
    logic [KEY_W-1:0]  tag_q;
    logic [PHASE_W-1:0] phase_raw;
    logic              res_valid;
    logic              res_ready;
    out_item_t         res_data;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    assign cfg_ready = 1'b1;

    // Sequencer.
    kpdf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .mem_req   (mem_req),
        .tag_q     (tag_q),
        .phase_q   (phase_t'(phase_raw)),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // Key tag of each slot.
    kpdf_ram #(
        .WIDTH (KEY_W),
        .DEPTH (POOL_SLOTS)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (mem_req.tag_we),
        .waddr (mem_req.wr_addr),
        .wdata (mem_req.tag_wdata),
        .raddr (mem_req.rd_addr),
        .rdata (tag_q)
    );

    // Phase of each slot.
    kpdf_ram #(
        .WIDTH (PHASE_W),
        .DEPTH (POOL_SLOTS)
    ) u_phase_ram (
        .aclk  (aclk),
        .we    (mem_req.phase_we),
        .waddr (mem_req.wr_addr),
        .wdata (PHASE_W'(mem_req.phase_wdata)),
        .raddr (mem_req.rd_addr),
        .rdata (phase_raw)
    );

    // Output register: loads when empty or when its result is being taken.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/kpdf_checker.sv =====
// Port-level checker for the keyed slot pool, bound to the top level.
`timescale 1ns / 1ps
module kpdf_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic                m_valid,
    input  logic                m_ready,
    input  kpdf_pkg::out_item_t m_data
);
    import kpdf_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Only a successful request carries a slot number.
    a_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STS_OK |-> m_data.granted_slot == '0)
        else $error("failed request reports a slot");

    // The block works on one request at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request accepted while one is in work");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind keyed_pool_deferred_free kpdf_checker u_kpdf_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the keyed slot pool: directed and random requests checked by a predictor.
module tb;
    import kpdf_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = POOL_SLOTS + 8;
    localparam int PHASE_REQUESTS = 205;
    localparam int PHASE_COUNT    = 6;

    // Tracks the pool contents, works out the result of each accepted request
    // and compares the results that come back in order.
    class pool_checker;
        logic [KEY_W-1:0] slot_key [POOL_SLOTS];
        phase_t           slot_phase [POOL_SLOTS];
        int               slots_used;
        int               key_limit;
        out_item_t        owed_results [$];
        int               mismatches;
        int               kinds_seen [4];
        int               status_seen [8];

        function new();
            slots_used = 0;
            key_limit  = int'(LIMIT_RESET);
            mismatches = 0;
            foreach (kinds_seen[i]) kinds_seen[i] = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_limit(logic [LIM_W-1:0] value);
            key_limit = int'(value);
        endfunction

        // Applies one accepted request to the pool and queues its result.
        function void note_request(in_item_t req);
            out_item_t res;
            int        owned;
            int        i;
            bit        found;
            res.status       = STS_OK;
            res.granted_slot = '0;
            case (req.kind)
                KIND_ADD: begin
                    if (req.key == KEY_NULL) begin
                        res.status = STS_NULL;
                    end else if (slots_used >= POOL_SLOTS) begin
                        res.status = STS_FULL;
                    end else begin
                        owned = 0;
                        for (i = 0; i < slots_used; i++) begin
                            if (slot_key[i] == req.key) owned++;
                        end
                        if (owned >= key_limit) begin
                            res.status = STS_LIMIT;
                        end else begin
                            slot_key[slots_used]   = req.key;
                            slot_phase[slots_used] = PH_FREE;
                            res.granted_slot       = SLOT_W'(slots_used);
                            slots_used++;
                        end
                    end
                end
                KIND_RESERVE: begin
                    if (req.key == KEY_NULL) begin
                        res.status = STS_NULL;
                    end else begin
                        found = 1'b0;
                        for (i = 0; i < slots_used && !found; i++) begin
                            if (slot_key[i] == req.key && slot_phase[i] == PH_FREE) begin
                                slot_phase[i]    = PH_BUSY;
                                res.granted_slot = SLOT_W'(i);
                                found            = 1'b1;
                            end
                        end
                        if (!found) res.status = STS_NONE;
                    end
                end
                KIND_RELEASE: begin
                    // A release moves the slot to pending whatever its phase.
                    if (int'(req.slot) >= slots_used) begin
                        res.status = STS_MISSING;
                    end else begin
                        slot_phase[req.slot] = PH_PENDING;
                    end
                end
                default: begin
                    for (i = 0; i < slots_used; i++) begin
                        if (slot_phase[i] == PH_PENDING) slot_phase[i] = PH_FREE;
                    end
                end
            endcase
            kinds_seen[int'(req.kind)]++;
            status_seen[int'(res.status)]++;
            owed_results.push_back(res);
        endfunction

        // Compares one accepted result with the oldest one owed.
        function void check_result(out_item_t got);
            out_item_t want;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: status %0d slot %0d", got.status,
                             got.granted_slot);
                end
            end else begin
                want = owed_results.pop_front();
                if (got.status !== want.status || got.granted_slot !== want.granted_slot) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                                 want.status, want.granted_slot, got.status,
                                 got.granted_slot);
                    end
                end
            end
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [LIM_W-1:0]     cfg_data  = '0;

    pool_checker          pool;
    int                   burst_left  = 8;
    int unsigned          cycle_count = 0;
    logic [15:0]          stall_mask  = 16'hFFFF;
    logic [3:0]           stall_pos   = '0;
    logic [KEY_W-1:0]     hot_keys [4];

    keyed_pool_deferred_free dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Give up on a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                     pool.owed_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // Result side: check each accepted result, stall on a 16-bit pattern
    // that is redrawn every pass and is sometimes all ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                pool.check_result(m_data);
            end
            m_ready   <= stall_mask[stall_pos];
            stall_pos <= stall_pos + 1'b1;
            if (stall_pos == 4'hF) begin
                stall_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                          : (16'($urandom()) | 16'h0001);
            end
        end
    end

    function automatic in_item_t mk(kind_t kind, logic [KEY_W-1:0] key,
                                    logic [SLOT_W-1:0] slot);
        in_item_t req;
        req.kind = kind;
        req.key  = key;
        req.slot = slot;
        return req;
    endfunction

    // Offers one request, waits for it to be taken and then, at the end of a
    // burst, leaves a random gap.
    task automatic issue(input in_item_t req);
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pool.note_request(req);
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 24);
        end
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        pool.set_limit(value);
    endtask

    task automatic drain_results();
        while (pool.owed_results.size() != 0) @(posedge aclk);
    endtask

    initial begin
        in_item_t         req;
        logic [LIM_W-1:0] phase_limit [PHASE_COUNT];
        int               roll;
        int               pick;

        pool        = new();
        hot_keys[0] = 8'hFF;
        hot_keys[1] = 8'h01;
        hot_keys[2] = 8'h5A;
        hot_keys[3] = 8'hA5;
        phase_limit[0] = 5'd0;
        phase_limit[1] = 5'd1;
        phase_limit[2] = 5'd2;
        phase_limit[3] = 5'd16;
        phase_limit[4] = 5'd31;
        phase_limit[5] = LIM_W'($urandom_range(1, 16));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty pool: tick, reserve with nothing appended, release of a missing slot.
        issue(mk(KIND_TICK, 8'h00, 4'h0));
        issue(mk(KIND_RESERVE, 8'h5A, 4'h0));
        issue(mk(KIND_RELEASE, 8'h00, 4'hF));
        // Null keys are refused on add and reserve.
        issue(mk(KIND_ADD, KEY_NULL, 4'h0));
        issue(mk(KIND_RESERVE, KEY_NULL, 4'hF));
        // Fill one key up to the reset limit of four, then one more.
        repeat (5) issue(mk(KIND_ADD, 8'hFF, 4'h0));
        issue(mk(KIND_RESERVE, 8'hFF, 4'h0));
        issue(mk(KIND_RESERVE, 8'hFF, 4'h0));
        // Release a busy slot twice and a free one: all end up pending.
        issue(mk(KIND_RELEASE, 8'h00, 4'h0));
        issue(mk(KIND_RELEASE, 8'hFF, 4'h0));
        issue(mk(KIND_RELEASE, 8'h00, 4'h2));
        issue(mk(KIND_RESERVE, 8'hFF, 4'h0));
        issue(mk(KIND_RESERVE, 8'hFF, 4'h0));
        // Tick frees the pending slots, so the lowest one is granted again.
        issue(mk(KIND_TICK, 8'hFF, 4'hF));
        issue(mk(KIND_RESERVE, 8'hFF, 4'h0));
        issue(mk(KIND_RELEASE, 8'h00, 4'h4));
        issue(mk(KIND_ADD, 8'h01, 4'hF));
        issue(mk(KIND_RESERVE, 8'h01, 4'hF));
        issue(mk(KIND_RESERVE, 8'h01, 4'h0));

        // Random phases, each under its own key limit, written while idle.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            s_valid <= 1'b0;
            drain_results();
            write_limit(phase_limit[p]);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                roll     = $urandom_range(0, 99);
                req.slot = SLOT_W'($urandom_range(0, 15));
                req.key  = KEY_W'($urandom_range(0, 255));
                if (roll < 4) begin
                    // Adds are rare so the pool fills over several limits.
                    req.kind = KIND_ADD;
                    pick     = $urandom_range(0, 9);
                    if (pick < 6) begin
                        req.key = hot_keys[$urandom_range(0, 3)];
                    end else if (pick == 6) begin
                        req.key = KEY_NULL;
                    end
                end else if (roll < 44) begin
                    // Mostly reserve keys that own slots.
                    req.kind = KIND_RESERVE;
                    pick     = $urandom_range(0, 19);
                    if (pick < 17 && pool.slots_used > 0) begin
                        req.key = pool.slot_key[$urandom_range(0, pool.slots_used - 1)];
                    end else if (pick == 17) begin
                        req.key = KEY_NULL;
                    end
                end else if (roll < 74) begin
                    req.kind = KIND_RELEASE;
                    if ($urandom_range(0, 9) < 8 && pool.slots_used > 0) begin
                        req.slot = SLOT_W'($urandom_range(0, pool.slots_used - 1));
                    end
                end else if (roll < 92) begin
                    req.kind = KIND_TICK;
                end else begin
                    req.kind = kind_t'($urandom_range(0, 3));
                end
                issue(req);
            end
        end

        s_valid <= 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d add, %0d reserve, %0d release and %0d tick requests under key limits",
                 pool.kinds_seen[KIND_ADD], pool.kinds_seen[KIND_RESERVE],
                 pool.kinds_seen[KIND_RELEASE], pool.kinds_seen[KIND_TICK]);
        $display("4, 0, 1, 2, 16, 31 and %0d; ok %0d, null %0d, full %0d, limit %0d, none %0d, missing %0d.",
                 phase_limit[PHASE_COUNT - 1], pool.status_seen[STS_OK],
                 pool.status_seen[STS_NULL], pool.status_seen[STS_FULL],
                 pool.status_seen[STS_LIMIT], pool.status_seen[STS_NONE],
                 pool.status_seen[STS_MISSING]);
        if (pool.mismatches == 0 && pool.owed_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
